>>> hw/rtl/sts_pkg.sv
// Shared types and constants for the sorted table with binary search.
// Holds the transfer payload structs, the sequencer states and the table port request.
// No dependencies.
`default_nettype none

package sts_pkg;

	// Table geometry.
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int VAL_W   = 32;
	localparam int POS_W   = 4;

	// Item kind codes.
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// One input item.
	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} out_item_t;

	// Request to the table memory: one write port, one registered read port.
	typedef struct packed {
		logic                    we;
		logic [IDX_W-1:0]        waddr;
		logic signed [VAL_W-1:0] wdata;
		logic                    re;
		logic [IDX_W-1:0]        raddr;
	} mem_req_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT_START,
		ST_SORT_CARRY,
		ST_SORT_READ,
		ST_SORT_CMP,
		ST_SORT_FLUSH,
		ST_SRCH_PROBE,
		ST_SRCH_CMP,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sts_table.sv
// Value table memory: one write port and one read port with registered read data.
// Depends on sts_pkg for the request struct and the table geometry.
`default_nettype none

module sts_table (
	input  wire logic                                 clk,
	input  wire sts_pkg::mem_req_t                    req,
	output logic signed [sts_pkg::VAL_W-1:0]          rdata
);

	logic signed [sts_pkg::VAL_W-1:0] mem_q [sts_pkg::ENTRIES];
	logic signed [sts_pkg::VAL_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Read port, data available in the following cycle.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/sts_seq.sv
// Sequencer for loads, the bubble sort and the binary search, with the value compares.
// Depends on sts_pkg; drives the table memory through a sts_pkg::mem_req_t request.
`default_nettype none

module sts_seq (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire sts_pkg::in_item_t                   item,
	output logic                                     idle,
	output sts_pkg::mem_req_t                        mem_req,
	input  wire logic signed [sts_pkg::VAL_W-1:0]    mem_rdata,
	input  wire logic                                res_free,
	output logic                                     res_load,
	output sts_pkg::out_item_t                       res
);

	localparam int CNT_W = sts_pkg::CNT_W;
	localparam int IDX_W = sts_pkg::IDX_W;
	localparam int VAL_W = sts_pkg::VAL_W;
	localparam int POS_W = sts_pkg::POS_W;

	sts_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        pass_q;
	logic [IDX_W-1:0]        k_q;
	logic signed [VAL_W-1:0] carry_q;
	logic signed [VAL_W-1:0] key_q;
	logic [CNT_W-1:0]        lo_q;
	logic [CNT_W-1:0]        hi1_q;
	logic [IDX_W-1:0]        mid_q;
	logic                    found_q;
	logic [POS_W-1:0]        pos_q;

	logic                    load_go;
	logic                    load_wr;
	logic [CNT_W-1:0]        count_next;
	logic                    carry_gt;
	logic                    k_last;
	logic                    pass_last;
	logic                    range_open;
	logic [CNT_W:0]          mid_sum;
	logic [IDX_W-1:0]        mid_c;
	logic [IDX_W+POS_W-1:0]  mid_ext;
	logic                    key_eq;
	logic                    key_lt;

	// Load bookkeeping: loads beyond capacity are dropped.
	assign load_go    = start && (item.kind == sts_pkg::KIND_LOAD);
	assign load_wr    = load_go && (count_q < CNT_W'(sts_pkg::ENTRIES));
	assign count_next = load_wr ? count_q + CNT_W'(1) : count_q;

	// Compares on the read data: the sort against the carry, the search against the key.
	assign carry_gt = carry_q > mem_rdata;
	assign key_eq   = mem_rdata == key_q;
	assign key_lt   = key_q < mem_rdata;

	// Sort loop bounds: a pass ends at index count-2, the sort after count-1 passes.
	assign k_last    = (CNT_W'(k_q) + CNT_W'(2)) == count_q;
	assign pass_last = (pass_q + CNT_W'(1)) == (count_q - CNT_W'(1));

	// Search window is [lo, hi1); middle = (lo + hi1 - 1) / 2.
	assign range_open = lo_q < hi1_q;
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi1_q} - (CNT_W + 1)'(1);
	assign mid_c      = mid_sum[IDX_W:1];
	assign mid_ext    = {{POS_W{1'b0}}, mid_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				if (start) begin
					if (item.kind == sts_pkg::KIND_SEARCH) begin
						state_d = sts_pkg::ST_SRCH_PROBE;
					end else if (item.last && (count_next >= CNT_W'(2))) begin
						state_d = sts_pkg::ST_SORT_START;
					end
				end
			end
			sts_pkg::ST_SORT_START: state_d = sts_pkg::ST_SORT_CARRY;
			sts_pkg::ST_SORT_CARRY: state_d = sts_pkg::ST_SORT_READ;
			sts_pkg::ST_SORT_READ:  state_d = sts_pkg::ST_SORT_CMP;
			sts_pkg::ST_SORT_CMP: begin
				state_d = k_last ? sts_pkg::ST_SORT_FLUSH : sts_pkg::ST_SORT_READ;
			end
			sts_pkg::ST_SORT_FLUSH: begin
				state_d = pass_last ? sts_pkg::ST_IDLE : sts_pkg::ST_SORT_START;
			end
			sts_pkg::ST_SRCH_PROBE: begin
				state_d = range_open ? sts_pkg::ST_SRCH_CMP : sts_pkg::ST_DONE;
			end
			sts_pkg::ST_SRCH_CMP: begin
				state_d = key_eq ? sts_pkg::ST_DONE : sts_pkg::ST_SRCH_PROBE;
			end
			sts_pkg::ST_DONE: begin
				if (res_free) begin
					state_d = sts_pkg::ST_IDLE;
				end
			end
			default: state_d = sts_pkg::ST_IDLE;
		endcase
	end

	// Outputs: table requests and result hand-off.
	always_comb begin
		mem_req       = '0;
		mem_req.wdata = item.value;
		idle          = 1'b0;
		res_load      = 1'b0;
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				idle          = 1'b1;
				mem_req.we    = load_wr;
				mem_req.waddr = count_q[IDX_W-1:0];
			end
			sts_pkg::ST_SORT_START: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = '0;
			end
			sts_pkg::ST_SORT_CARRY: begin
			end
			sts_pkg::ST_SORT_READ: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = k_q + IDX_W'(1);
			end
			sts_pkg::ST_SORT_CMP: begin
				// The smaller of the pair settles at k; the larger moves on as the carry.
				mem_req.we    = 1'b1;
				mem_req.waddr = k_q;
				mem_req.wdata = carry_gt ? mem_rdata : carry_q;
			end
			sts_pkg::ST_SORT_FLUSH: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = IDX_W'(count_q - CNT_W'(1));
				mem_req.wdata = carry_q;
			end
			sts_pkg::ST_SRCH_PROBE: begin
				mem_req.re    = range_open;
				mem_req.raddr = mid_c;
			end
			sts_pkg::ST_SRCH_CMP: begin
			end
			sts_pkg::ST_DONE: begin
				res_load = res_free;
			end
			default: begin
			end
		endcase
	end

	assign res.found    = found_q;
	assign res.position = pos_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sts_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sts_pkg::ST_IDLE) begin
				count_q <= count_next;
			end
		end
	end

	// Working registers of the sort and the search.
	always_ff @(posedge clk) begin
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				pass_q  <= '0;
				lo_q    <= '0;
				hi1_q   <= count_q;
				key_q   <= item.value;
				found_q <= 1'b0;
				pos_q   <= '0;
			end
			sts_pkg::ST_SORT_START: begin
				k_q <= '0;
			end
			sts_pkg::ST_SORT_CARRY: begin
				carry_q <= mem_rdata;
			end
			sts_pkg::ST_SORT_READ: begin
			end
			sts_pkg::ST_SORT_CMP: begin
				if (!carry_gt) begin
					carry_q <= mem_rdata;
				end
				k_q <= k_q + IDX_W'(1);
			end
			sts_pkg::ST_SORT_FLUSH: begin
				pass_q <= pass_q + CNT_W'(1);
			end
			sts_pkg::ST_SRCH_PROBE: begin
				mid_q <= mid_c;
			end
			sts_pkg::ST_SRCH_CMP: begin
				if (key_eq) begin
					found_q <= 1'b1;
					pos_q   <= mid_ext[POS_W-1:0];
				end else if (key_lt) begin
					hi1_q <= CNT_W'(mid_q);
				end else begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end
			end
			sts_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// The fill count never passes the table size.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(sts_pkg::ENTRIES))
		else $error("entry count beyond table size");

	// A search never writes the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sts_pkg::ST_SRCH_PROBE || state_q == sts_pkg::ST_SRCH_CMP
		 || state_q == sts_pkg::ST_DONE) |-> !mem_req.we)
		else $error("table written during a search");

	// Sort compares stay inside the loaded entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sts_pkg::ST_SORT_CMP) |-> ((CNT_W'(k_q) + CNT_W'(1)) < count_q))
		else $error("sort compare beyond loaded entries");

	// A miss always reports position zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && !res.found) |-> (res.position == '0))
		else $error("miss with a nonzero position");

	// A search probe only reads loaded entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sts_pkg::ST_SRCH_PROBE && range_open) |-> (CNT_W'(mid_c) < count_q))
		else $error("search probe beyond loaded entries");

endmodule

`default_nettype wire

>>> hw/rtl/sorted_table_binary_search.sv
// Sorted table with binary search: top level with the result register.
// Depends on sts_pkg, sts_table and sts_seq.
`default_nettype none

// Loads append signed 32-bit values to a 16-entry table; loads beyond 16 are dropped.
// A load marked last sorts the held entries ascending by bubble sort, and a search
// returns found and the zero-based position by binary search. A load that starts no
// sort is written directly, so loads are taken back to back. After it is accepted, a
// search makes at most floor(log2(n))+1 probes over n held entries, each a read
// through the single table read port with its registered data and then a compare; a
// miss ends with a closing range check, and the result hand-off waits while the
// output register stays occupied. The sort after the last load takes (n-1) passes,
// paced by one table read and one table write per compare. The input is not ready
// while a sort or search runs; a finished result waits in an output register, so the
// next item can be taken while the previous result has not yet been transferred.
module sorted_table_binary_search (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire sts_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output sts_pkg::out_item_t      result
);

	sts_pkg::mem_req_t                mem_req;
	logic signed [sts_pkg::VAL_W-1:0] mem_rdata;
	logic                             seq_idle;
	logic                             start;
	logic                             res_free;
	logic                             res_load;
	sts_pkg::out_item_t               res;
	logic                             result_valid_q;
	sts_pkg::out_item_t               result_q;

	// Input transfer handshake.
	assign item_ready = seq_idle;
	assign start      = item_valid && item_ready;

	// The result register frees up when empty or when its transfer completes.
	assign res_free = !result_valid_q || result_ready;

	sts_table u_table (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	sts_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.idle      (seq_idle),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_free  (res_free),
		.res_load  (res_load),
		.res       (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted table with binary search.
// Directed rows first, then random loads and searches; each answer is checked against its
// typed row or a shadow of the table. Depends on sts_pkg and sorted_table_binary_search.
module tb_top;

	localparam int VAL_W = sts_pkg::VAL_W;
	localparam int POS_W = sts_pkg::POS_W;

	localparam logic signed [VAL_W-1:0] MIN_VAL = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int IDLE_PCT      = 36;
	localparam int HOLD_AFTER    = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam int PAUSE_AT      = 700;
	localparam int BURST_FIRST   = 350;
	localparam int BURST_LAST    = 550;
	localparam int SETTLE_CYCLES = 500;

	// One row of the directed part; answer is used only where typed is set.
	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic                    typed;
		sts_pkg::out_item_t      answer;
	} step_t;

	localparam sts_pkg::out_item_t MISS       = '{1'b0, 4'd0};
	localparam sts_pkg::out_item_t FOUND_AT_0 = '{1'b1, 4'd0};
	localparam sts_pkg::out_item_t FOUND_AT_3 = '{1'b1, 4'd3};

	localparam step_t DIRECTED [22] = '{
		// Searches on the empty table, one of them marked last.
		'{sts_pkg::KIND_SEARCH, 32'sd0,   1'b0, 1'b1, MISS},
		'{sts_pkg::KIND_SEARCH, MIN_VAL,  1'b1, 1'b1, MISS},
		'{sts_pkg::KIND_SEARCH, MAX_VAL,  1'b0, 1'b1, MISS},
		// Three loads, then searches before any sort.
		'{sts_pkg::KIND_LOAD,   32'sd5,   1'b0, 1'b0, MISS},
		'{sts_pkg::KIND_LOAD,   -32'sd3,  1'b0, 1'b0, MISS},
		'{sts_pkg::KIND_LOAD,   MAX_VAL,  1'b0, 1'b0, MISS},
		'{sts_pkg::KIND_SEARCH, 32'sd5,   1'b0, 1'b0, MISS},
		'{sts_pkg::KIND_SEARCH, -32'sd3,  1'b0, 1'b0, MISS},
		// The last load sorts; both extremes are then found at the ends.
		'{sts_pkg::KIND_LOAD,   MIN_VAL,  1'b1, 1'b0, MISS},
		'{sts_pkg::KIND_SEARCH, MIN_VAL,  1'b0, 1'b1, FOUND_AT_0},
		'{sts_pkg::KIND_SEARCH, MAX_VAL,  1'b0, 1'b1, FOUND_AT_3},
		'{sts_pkg::KIND_SEARCH, 32'sd4,   1'b0, 1'b1, MISS},
		// Duplicate keys after a second sort.
		'{sts_pkg::KIND_LOAD,   32'sd5,   1'b0, 1'b0, MISS},
		'{sts_pkg::KIND_LOAD,   32'sd5,   1'b1, 1'b0, MISS},
		'{sts_pkg::KIND_SEARCH, 32'sd5,   1'b0, 1'b0, MISS},
		// A load after the sort appends behind the sorted entries.
		'{sts_pkg::KIND_LOAD,   -32'sd1,  1'b0, 1'b0, MISS},
		'{sts_pkg::KIND_SEARCH, -32'sd1,  1'b0, 1'b0, MISS},
		'{sts_pkg::KIND_SEARCH, MAX_VAL,  1'b0, 1'b0, MISS},
		'{sts_pkg::KIND_SEARCH, 32'sd0,   1'b1, 1'b0, MISS},
		'{sts_pkg::KIND_LOAD,   32'sd0,   1'b1, 1'b0, MISS},
		'{sts_pkg::KIND_SEARCH, 32'sd0,   1'b0, 1'b0, MISS},
		'{sts_pkg::KIND_SEARCH, -32'sd3,  1'b0, 1'b0, MISS}
	};

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	sts_pkg::in_item_t  item         = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	sts_pkg::out_item_t result;

	// Shadow state of the block and the answers still owed by it.
	logic signed [VAL_W-1:0] shadow_table [sts_pkg::ENTRIES];
	int                 shadow_count  = 0;
	sts_pkg::out_item_t pending_answers [$];
	int                 mismatch_count = 0;
	int                 delivered_count = 0;
	logic               no_idle = 1'b0;

	sorted_table_binary_search DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Free-running clock with a 10 ns period.
	always begin
		#5;
		clk = 1'b1;
		#5;
		clk = 1'b0;
	end

	// Hard limit on the run time.
	initial begin
		#25_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Appends a value when there is room; a load marked last bubble-sorts the held entries.
	function automatic void store_value(logic signed [VAL_W-1:0] v, logic mark_last);
		logic signed [VAL_W-1:0] swap;
		if (shadow_count < sts_pkg::ENTRIES) begin
			shadow_table[shadow_count] = v;
			shadow_count++;
		end
		if (mark_last) begin
			for (int pass = 0; pass < shadow_count; pass++) begin
				for (int k = 0; k + 1 < shadow_count; k++) begin
					if (shadow_table[k] > shadow_table[k + 1]) begin
						swap                = shadow_table[k];
						shadow_table[k]     = shadow_table[k + 1];
						shadow_table[k + 1] = swap;
					end
				end
			end
		end
	endfunction

	// Binary search over the held entries as they stand, sorted or not.
	function automatic sts_pkg::out_item_t lookup_key(logic signed [VAL_W-1:0] key);
		sts_pkg::out_item_t ans;
		int lo;
		int hi;
		int mid;
		ans = MISS;
		lo  = 0;
		hi  = shadow_count - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (shadow_table[mid] == key) begin
				ans.found    = 1'b1;
				ans.position = POS_W'(mid);
				return ans;
			end
			if (key < shadow_table[mid]) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return ans;
	endfunction

	// Values that favor the extremes and a narrow band where duplicates are likely.
	function automatic logic signed [VAL_W-1:0] random_value();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: return MIN_VAL;
					1: return MAX_VAL;
					2: return '0;
					default: return '1;
				endcase
			end
			1: return $signed($urandom_range(16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// Search keys: mostly held values, some neighbors of held values, some anything.
	function automatic logic signed [VAL_W-1:0] random_key();
		logic signed [VAL_W-1:0] pick;
		if (shadow_count == 0) begin
			return random_value();
		end
		pick = shadow_table[$urandom_range(shadow_count - 1)];
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return pick;
			5: return pick + 1;
			6: return pick - 1;
			default: return random_value();
		endcase
	endfunction

	// Offers one item after a random gap and returns at the edge of its transfer.
	task automatic offer_item(input sts_pkg::in_item_t pkt);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= pkt;
		do @(posedge clk); while (!item_ready);
	endtask

	// Sends one item and updates the shadow state or the owed answers.
	task automatic run_item(input sts_pkg::in_item_t pkt, input logic typed,
		input sts_pkg::out_item_t typed_ans);
		offer_item(pkt);
		if (pkt.kind == sts_pkg::KIND_SEARCH) begin
			pending_answers.push_back(typed ? typed_ans : lookup_key(pkt.value));
		end else begin
			store_value(pkt.value, pkt.last);
		end
	endtask

	// Compares one result transfer with the oldest owed answer.
	function automatic void check_answer(sts_pkg::out_item_t got);
		sts_pkg::out_item_t want;
		if (pending_answers.size() == 0) begin
			$error("result transfer with no search outstanding: found=%0d position=%0d",
				got.found, got.position);
			mismatch_count++;
			return;
		end
		want = pending_answers.pop_front();
		if (got.found !== want.found) begin
			$error("found: expected %0d, actual %0d", want.found, got.found);
			mismatch_count++;
		end
		if (got.position !== want.position) begin
			$error("position: expected %0d, actual %0d", want.position, got.position);
			mismatch_count++;
		end
	endfunction

	// Result side: checks transfers, stalls at random, and holds off once for a long stretch.
	initial begin : result_side
		logic held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				check_answer(result);
				delivered_count++;
			end
			if (!held && delivered_count >= HOLD_AFTER) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Item side: reset, the directed rows, the random part, then the final verdict.
	initial begin : item_side
		sts_pkg::in_item_t pkt;
		int                sent;
		logic              paused;
		logic              ignored;
		int                load_pct;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			pkt.kind  = DIRECTED[i].kind;
			pkt.value = DIRECTED[i].value;
			pkt.last  = DIRECTED[i].last;
			run_item(pkt, DIRECTED[i].typed, DIRECTED[i].answer);
		end

		// Loads are frequent until the table fills; after that they are dropped.
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			no_idle <= (sent >= BURST_FIRST && sent < BURST_LAST);
			if (!paused && sent == PAUSE_AT) begin
				paused = 1'b1;
				item_valid <= 1'b0;
				@(posedge clk);
				while (pending_answers.size() != 0) @(posedge clk);
			end
			load_pct  = (shadow_count < sts_pkg::ENTRIES) ? 15 : 3;
			pkt.kind  = ($urandom_range(99) < load_pct) ? sts_pkg::KIND_LOAD
				: sts_pkg::KIND_SEARCH;
			pkt.last  = ($urandom_range(3) == 0);
			pkt.value = (pkt.kind == sts_pkg::KIND_LOAD) ? random_value() : random_key();
			ignored   = (pkt.kind == sts_pkg::KIND_LOAD)
				&& (shadow_count >= sts_pkg::ENTRIES) && !pkt.last;
			run_item(pkt, 1'b0, MISS);
			if (!ignored) begin
				sent++;
			end
		end

		// Drain the owed answers, then allow for a trailing sort.
		item_valid <= 1'b0;
		no_idle    <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
